// ===== hdl/fpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpt_pkg
// Shared constants, types and helpers for the FTP passive port tracker.
// ----------------------------------------------------------------------------
package fpt_pkg;

	localparam int TABLE_DEPTH = 128;
	localparam int SCAN_LIMIT  = 511;
	localparam int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW          = $clog2(TABLE_DEPTH + 1);
	localparam int BPW         = $clog2(SCAN_LIMIT + 1);
	localparam int LIT_LEN     = 25;
	localparam logic [16:0] NUM_SAT = 17'd131071;

	localparam logic ACT_CLASSIFY = 1'b0;
	localparam logic ACT_BYTE     = 1'b1;

	localparam logic [1:0] REG_CONTROL_PORT = 2'd0;
	localparam logic [1:0] REG_ACTIVE_PORT  = 2'd1;

	typedef enum logic [2:0] {
		PH_SEARCH, PH_PAREN, PH_START, PH_SIGN, PH_DIGITS
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE, ST_SWEEP, ST_DONE
	} ctl_state_t;

	typedef struct packed {
		logic        is_control;
		logic        is_data;
		logic        port_learned;
		logic [15:0] learned_port;
		logic        table_full;
	} result_t;

	function automatic logic [7:0] lit_char(input logic [4:0] i);
		logic [7:0] c;
		case (i)
			5'd0: c = "2";  5'd1: c = "2";  5'd2: c = "7";  5'd3: c = " ";
			5'd4: c = "E";  5'd5: c = "n";  5'd6: c = "t";  5'd7: c = "e";
			5'd8: c = "r";  5'd9: c = "i";  5'd10: c = "n"; 5'd11: c = "g";
			5'd12: c = " "; 5'd13: c = "P"; 5'd14: c = "a"; 5'd15: c = "s";
			5'd16: c = "s"; 5'd17: c = "i"; 5'd18: c = "v"; 5'd19: c = "e";
			5'd20: c = " "; 5'd21: c = "M"; 5'd22: c = "o"; 5'd23: c = "d";
			5'd24: c = "e";
			default: c = 8'd0;
		endcase
		return c;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'd48) && (c <= 8'd57);
	endfunction

endpackage

// ===== hdl/fpt_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpt_in_if / fpt_out_if
// Valid/ready channels carrying tracker items and results.
// ----------------------------------------------------------------------------
interface fpt_in_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [15:0] sport;
	logic [15:0] dport;
	logic [7:0]  data_byte;
	logic        last_byte;
	modport source (output valid, action, sport, dport, data_byte, last_byte,
		input ready);
	modport sink (input valid, action, sport, dport, data_byte, last_byte,
		output ready);
endinterface

interface fpt_out_if;
	logic        valid;
	logic        ready;
	logic        is_control;
	logic        is_data;
	logic        port_learned;
	logic [15:0] learned_port;
	logic        table_full;
	modport source (output valid, is_control, is_data, port_learned, learned_port,
		table_full, input ready);
	modport sink (input valid, is_control, is_data, port_learned, learned_port,
		table_full, output ready);
endinterface

// ===== hdl/ftp_passive_port_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftp_passive_port_tracker
// Classifies packets by TCP port and learns passive data ports from
// "227 Entering Passive Mode (h,h,h,h,p1,p2)" control replies.
// ----------------------------------------------------------------------------
// channel   dir  transfer
// in_ch     in   classify query (action 0) or one payload byte (action 1)
// out_ch    out  one result per input item
// apb       in   control_port (0x0), active_data_port (0x4)
//
// Payload byte: accepted, then its result is registered. Classify: sweeps the
// port table with one RAM read per learned entry; the port table sits in one
// RAM with a single port, swept one entry per cycle.
// Reset (arst_n) clears the scanner and entry count; no table clearing pass.
// One item in flight; out_ch stall holds the result and blocks the next accept.
// ----------------------------------------------------------------------------
module ftp_passive_port_tracker (
	input  logic        clk,
	input  logic        arst_n,
	fpt_in_if.sink      in_ch,
	fpt_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import fpt_pkg::*;

	logic [15:0] control_port_q, active_port_q;
	ctl_state_t  state_q, state_d;
	logic [CW-1:0] count_q;
	logic [4:0]  mpos_q;
	phase_t      phase_q;
	logic [16:0] num_q, high_q;
	logic [BPW-1:0] bpos_q;
	logic        stopped_q;

	logic [15:0] sp_q, dp_q;
	logic        hit_q;
	logic [CW-1:0] idx_q;
	logic        rd_pending_q;
	result_t     res_q;
	logic        out_valid_q;

	logic        ram_we;
	logic [AW-1:0] ram_addr;
	logic [15:0] ram_rdata;

	logic        cfg_wr;
	logic        acc;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	always_comb begin
		unique case (paddr[2])
			REG_CONTROL_PORT[0]: prdata = {16'd0, control_port_q};
			default:             prdata = {16'd0, active_port_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_port_q <= 16'd21;
			active_port_q  <= 16'd20;
		end else if (cfg_wr && paddr[1:0] == 2'd0) begin
			if (paddr[2] == REG_CONTROL_PORT[0]) control_port_q <= pwdata[15:0];
			else if (paddr[2] == REG_ACTIVE_PORT[0]) active_port_q <= pwdata[15:0];
		end
	end

	assign in_ch.ready = (state_q == ST_IDLE) && !out_valid_q;
	assign acc = in_ch.valid && in_ch.ready;

	// ---- byte scanner (combinational next state) ----
	logic [7:0]  c;
	logic [4:0]  mp_n, mp_s;
	phase_t      ph_n;
	logic [16:0] num_n, high_n;
	logic        stop_n, complete, do_learn, do_full, act;
	logic [20:0] num_x10;
	logic [17:0] port_calc;
	logic        at_limit;

	always_comb begin
		c = in_ch.data_byte;
		mp_n = mpos_q;
		ph_n = phase_q;
		num_n = num_q;
		high_n = high_q;
		stop_n = stopped_q;
		complete = 1'b0;
		num_x10 = 21'd0;
		act = !stopped_q && (bpos_q < BPW'(SCAN_LIMIT));
		at_limit = (bpos_q + BPW'(1)) >= BPW'(SCAN_LIMIT);
		mp_s = 5'd0;
		if (act) begin
			if (c == 8'd0) begin
				if (phase_q == PH_DIGITS && mpos_q == 5'd5) complete = 1'b1;
				stop_n = 1'b1;
			end else begin
				unique case (phase_q)
					PH_SEARCH: begin
						// failure function is 0 except after "22" -> 1
						if (c == lit_char(mpos_q)) mp_s = mpos_q;
						else if (mpos_q == 5'd2 && c == lit_char(5'd1)) mp_s = 5'd1;
						else if (mpos_q != 5'd0 && c == lit_char(5'd0)) mp_s = 5'd0;
						else mp_s = 5'd31;
						if (mp_s == 5'd31) mp_n = 5'd0;
						else mp_n = mp_s + 5'd1;
						if (mp_n >= 5'(LIT_LEN)) begin
							mp_n = 5'd0;
							ph_n = PH_PAREN;
						end
					end
					PH_PAREN: begin
						if (c == 8'd40) ph_n = PH_START;
						else if (!is_space(c)) stop_n = 1'b1;
					end
					PH_START: begin
						if (is_digit(c)) begin
							num_n = 17'(c - 8'd48);
							ph_n = PH_DIGITS;
						end else if (c == 8'd43) ph_n = PH_SIGN;
						else if (!is_space(c)) stop_n = 1'b1;
					end
					PH_SIGN: begin
						if (is_digit(c)) begin
							num_n = 17'(c - 8'd48);
							ph_n = PH_DIGITS;
						end else stop_n = 1'b1;
					end
					default: begin
						if (is_digit(c)) begin
							num_x10 = {num_q, 3'd0} + {3'd0, num_q, 1'b0} + 21'(c - 8'd48);
							num_n = (num_x10 > 21'(NUM_SAT)) ? NUM_SAT : num_x10[16:0];
						end else if (mpos_q >= 5'd5) begin
							complete = 1'b1;
						end else if (c == 8'd44) begin
							if (mpos_q == 5'd4) high_n = num_q;
							mp_n = mpos_q + 5'd1;
							num_n = 17'd0;
							ph_n = PH_START;
						end else stop_n = 1'b1;
					end
				endcase
				if (!stop_n && !complete && (in_ch.last_byte || at_limit)) begin
					if (ph_n == PH_DIGITS && mp_n == 5'd5) complete = 1'b1;
					stop_n = 1'b1;
				end
			end
		end
		// port = high*256 + num; high above 255 always overflows 65535
		port_calc = {2'd0, high_n[7:0], 8'd0} + {1'b0, num_n};
		if (complete) stop_n = 1'b1;
		do_learn = 1'b0;
		do_full = 1'b0;
		if (complete && high_n[16:8] == 9'd0 && port_calc <= 18'd65535) begin
			if (count_q < CW'(TABLE_DEPTH)) do_learn = 1'b1;
			else do_full = 1'b1;
		end
	end

	// ---- classify sweep FSM ----
	logic sweep_hit;
	assign sweep_hit = rd_pending_q && (ram_rdata == sp_q || ram_rdata == dp_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (acc && in_ch.action == ACT_CLASSIFY) state_d = ST_SWEEP;
			ST_SWEEP: if (idx_q >= count_q && !rd_pending_q) state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ram_we = acc && in_ch.action == ACT_BYTE && do_learn;
		ram_addr = ram_we ? count_q[AW-1:0] : idx_q[AW-1:0];
	end

	fpt_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_table (
		.clk(clk), .we(ram_we), .addr(ram_addr),
		.wdata(port_calc[15:0]), .rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			mpos_q <= '0;
			phase_q <= PH_SEARCH;
			num_q <= '0;
			high_q <= '0;
			bpos_q <= '0;
			stopped_q <= 1'b0;
			out_valid_q <= 1'b0;
			rd_pending_q <= 1'b0;
			idx_q <= '0;
			hit_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			if (acc && in_ch.action == ACT_BYTE) begin
				out_valid_q <= 1'b1;
				res_q.is_control <= 1'b0;
				res_q.is_data <= 1'b0;
				res_q.port_learned <= do_learn;
				res_q.learned_port <= do_learn ? port_calc[15:0] : 16'd0;
				res_q.table_full <= do_full;
				if (do_learn) count_q <= count_q + CW'(1);
				if (in_ch.last_byte) begin
					mpos_q <= '0;
					phase_q <= PH_SEARCH;
					num_q <= '0;
					high_q <= '0;
					bpos_q <= '0;
					stopped_q <= 1'b0;
				end else begin
					mpos_q <= mp_n;
					phase_q <= ph_n;
					num_q <= num_n;
					high_q <= high_n;
					stopped_q <= stop_n;
					if (act) bpos_q <= bpos_q + BPW'(1);
				end
			end
			if (acc && in_ch.action == ACT_CLASSIFY) begin
				sp_q <= in_ch.sport;
				dp_q <= in_ch.dport;
				hit_q <= (in_ch.sport == active_port_q || in_ch.dport == active_port_q);
				res_q.is_control <= (in_ch.sport == control_port_q ||
					in_ch.dport == control_port_q);
				idx_q <= '0;
				rd_pending_q <= 1'b0;
			end
			if (state_q == ST_SWEEP) begin
				rd_pending_q <= idx_q < count_q;
				if (idx_q < count_q) idx_q <= idx_q + CW'(1);
				if (sweep_hit) hit_q <= 1'b1;
			end
			if (state_q == ST_DONE) begin
				out_valid_q <= 1'b1;
				res_q.is_data <= hit_q;
				res_q.port_learned <= 1'b0;
				res_q.learned_port <= 16'd0;
				res_q.table_full <= 1'b0;
			end
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.is_control   = res_q.is_control;
	assign out_ch.is_data      = res_q.is_data;
	assign out_ch.port_learned = res_q.port_learned;
	assign out_ch.learned_port = res_q.learned_port;
	assign out_ch.table_full   = res_q.table_full;
endmodule

// ===== hdl/fpt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpt_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module fpt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ===== hdl/fpt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpt_checker
// Port-level assertions for the passive port tracker.
// ----------------------------------------------------------------------------
module fpt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        is_control,
	input logic        is_data,
	input logic        port_learned,
	input logic [15:0] learned_port,
	input logic        table_full
);
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(learned_port))
		else $error("result changed under stall");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("accept while result pending");
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !((is_control || is_data) && (port_learned || table_full)))
		else $error("mixed result kinds");
	a_learn_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(port_learned && table_full)) else $error("learn and full");
	a_port_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !port_learned |-> learned_port == 16'd0)
		else $error("stray learned port");
endmodule

bind ftp_passive_port_tracker fpt_checker u_fpt_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.is_control(out_ch.is_control), .is_data(out_ch.is_data),
	.port_learned(out_ch.port_learned), .learned_port(out_ch.learned_port),
	.table_full(out_ch.table_full)
);
